// ===== src/tteq_pkg.sv =====
// ============================================================================
// tteq_pkg: shared types and constants of the timestamped tagged event queue
// Holds the request and result records, the operation and status codes,
// and the fixed queue depth that the width of the queued count must hold.
// ============================================================================
package tteq_pkg;

    // Fixed sizes of the request and result fields.
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int TIME_W      = 64;
    localparam int TAG_W       = 32;
    localparam int COUNT_W     = 5;

    // Number of events in the ring. The queued count field is sized for it.
    localparam int QUEUE_DEPTH = 16;

    // Operation codes carried in the kind field.
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH    = 3'd0,
        KIND_ADD_TAG = 3'd1,
        KIND_POP     = 3'd2,
        KIND_LOOKUP  = 3'd3,
        KIND_CLEAR   = 3'd4
    } kind_t;

    // Status codes reported with every result.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_EMPTY     = 3'd2,
        STATUS_TAGS_FULL = 3'd3,
        STATUS_NO_HELD   = 3'd4
    } status_t;

    // One request.
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [TIME_W-1:0]       event_time;
        logic signed [TAG_W-1:0] tag_value;
        logic signed [TAG_W-1:0] tag_data;
    } cmd_t;

    // One result.
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic                    time_clamped;
        logic [TIME_W-1:0]       popped_time;
        logic                    tag_found;
        logic signed [TAG_W-1:0] found_data;
        logic [TIME_W-1:0]       head_time;
        logic [COUNT_W-1:0]      queued_count;
    } res_t;

endpackage

// ===== src/timestamped_tagged_event_queue.sv =====
// ============================================================================
// timestamped_tagged_event_queue: FIFO of timestamped events with tag lists
// Usage: requests arrive on cmd (cmd_valid, cmd_stall) and each one yields
// exactly one result on res (res_valid, res_stall), in request order.
// For push, add-tag, lookup and clear the result is in the
// output queue on the cycle after acceptance. A pop that finds the queue
// non-empty goes through a load state: the head slot is read from the synchronous
// event memories at acceptance, and the held event is loaded and searched
// on the next cycle. The registered read of the memories is why a pop needs
// the load state. A two-entry output queue lets a new request in while a result
// waits; cmd_stall rises while a pop is loading or the output queue is full.
// Reset empties the queue, drops the held event and the pending results.
// The event memories need no clearing pass: the head, tail and count
// registers tell which slots hold events. A stalled receiver backs the
// output queue up and then stalls the request side.
// ============================================================================
module timestamped_tagged_event_queue
    import tteq_pkg::*;
#(
    parameter int TAGS_PER_EVENT = 5
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int TCNT_W = $clog2(TAGS_PER_EVENT + 1);
    localparam int LANE_W = (TAGS_PER_EVENT > 1) ? $clog2(TAGS_PER_EVENT) : 1;
    localparam logic [PTR_W-1:0]   LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);
    localparam logic [TCNT_W-1:0]  TAGS_MAX   = TCNT_W'(TAGS_PER_EVENT);
    localparam logic [1:0]         OUT_SLOTS  = 2'd2;

    typedef logic [TAGS_PER_EVENT-1:0][TAG_W-1:0] tag_row_t;

    typedef struct packed {
        logic             found;
        logic [TAG_W-1:0] data;
    } match_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP_LOAD
    } state_t;

    // Next slot in the ring.
    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    // Parallel compare over the used tag slots; the lowest slot wins.
    function automatic match_t search_row(
        input tag_row_t            keys,
        input tag_row_t            words,
        input logic [TCNT_W-1:0]   used,
        input logic [TAG_W-1:0]    query
    );
        match_t m;
        m.found = 1'b0;
        m.data  = '1;
        for (int k = TAGS_PER_EVENT - 1; k >= 0; k--) begin
            if ((TCNT_W'(k) < used) && (keys[k] == query)) begin
                m.found = 1'b1;
                m.data  = words[k];
            end
        end
        return m;
    endfunction

    // Event memories, one entry per ring slot.
    logic [TIME_W-1:0] time_mem [QUEUE_DEPTH];
    logic [TCNT_W-1:0] tcnt_mem [QUEUE_DEPTH];
    tag_row_t          key_mem  [QUEUE_DEPTH];
    tag_row_t          word_mem [QUEUE_DEPTH];

    // Control state.
    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0]   tail_ptr_reg, tail_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0]  newest_time_reg, newest_time_next;
    logic [TCNT_W-1:0]  newest_tcnt_reg, newest_tcnt_next;
    logic [TIME_W-1:0]  head_time_reg, head_time_next;
    logic               held_valid_reg, held_valid_next;
    logic [1:0]         fill_reg, fill_next;
    logic               wr_sel_reg, rd_sel_reg;

    // Held event and memory read data.
    logic [TIME_W-1:0]  held_time_reg;
    logic [TCNT_W-1:0]  held_tcnt_reg;
    tag_row_t           held_keys_reg, held_words_reg;
    logic [TIME_W-1:0]  rd_time_reg, rd_next_time_reg;
    logic [TCNT_W-1:0]  rd_tcnt_reg;
    tag_row_t           rd_keys_reg, rd_words_reg;
    logic [TAG_W-1:0]   query_reg;

    // Output queue.
    res_t               out_q_reg [2];

    // Request decode and datapath signals.
    kind_t              kind;
    logic               acc;
    logic               is_empty, is_full;
    logic [PTR_W-1:0]   newest_slot;
    logic [PTR_W-1:0]   head_inc;
    logic [LANE_W-1:0]  lane;
    logic               clamp;
    logic [TIME_W-1:0]  push_time;
    match_t             held_match, pop_match;
    logic               time_we, tcnt_we, tag_we, rd_en;
    logic [PTR_W-1:0]   tcnt_addr;
    logic [TCNT_W-1:0]  tcnt_wdata;
    res_t               res_now, res_pop, wr_data;
    logic               wr_en, rd_take;

    assign kind        = kind_t'(cmd.kind);
    assign cmd_stall   = !((state_reg == ST_IDLE) && (fill_reg != OUT_SLOTS));
    assign acc         = cmd_valid && !cmd_stall;
    assign is_empty    = (count_reg == '0);
    assign is_full     = (count_reg == FULL_COUNT);
    assign newest_slot = (tail_ptr_reg == '0) ? LAST_SLOT : tail_ptr_reg - 1'b1;
    assign head_inc    = wrap_inc(head_ptr_reg);
    assign lane        = newest_tcnt_reg[LANE_W-1:0];

    // Timestamps never run backward: a late push takes the newest time.
    assign clamp     = !is_empty && (cmd.event_time < newest_time_reg);
    assign push_time = clamp ? newest_time_reg : cmd.event_time;

    assign held_match = search_row(held_keys_reg, held_words_reg, held_tcnt_reg,
                                   cmd.tag_value);
    assign pop_match  = search_row(rd_keys_reg, rd_words_reg, rd_tcnt_reg, query_reg);

    // Operation decode, next control state and the immediate result.
    always_comb
    begin
        state_next       = state_reg;
        head_ptr_next    = head_ptr_reg;
        tail_ptr_next    = tail_ptr_reg;
        count_next       = count_reg;
        newest_time_next = newest_time_reg;
        newest_tcnt_next = newest_tcnt_reg;
        head_time_next   = head_time_reg;
        held_valid_next  = held_valid_reg;
        time_we          = 1'b0;
        tcnt_we          = 1'b0;
        tag_we           = 1'b0;
        rd_en            = 1'b0;
        tcnt_addr        = tail_ptr_reg;
        tcnt_wdata       = '0;
        res_now          = '0;
        res_now.status   = STATUS_OK;
        res_now.found_data = '1;

        if (state_reg == ST_POP_LOAD) begin
            state_next      = ST_IDLE;
            held_valid_next = 1'b1;
            head_time_next  = rd_next_time_reg;
        end else if (acc) begin
            case (kind)
                KIND_PUSH:
                begin
                    if (is_full) begin
                        res_now.status = STATUS_FULL;
                    end else begin
                        time_we          = 1'b1;
                        tcnt_we          = 1'b1;
                        tail_ptr_next    = wrap_inc(tail_ptr_reg);
                        count_next       = count_reg + 1'b1;
                        newest_time_next = push_time;
                        newest_tcnt_next = '0;
                        if (is_empty) begin
                            head_time_next = push_time;
                        end
                        res_now.time_clamped = clamp;
                    end
                end
                KIND_ADD_TAG:
                begin
                    if (is_empty) begin
                        res_now.status = STATUS_EMPTY;
                    end else if (newest_tcnt_reg >= TAGS_MAX) begin
                        res_now.status = STATUS_TAGS_FULL;
                    end else begin
                        tag_we           = 1'b1;
                        tcnt_we          = 1'b1;
                        tcnt_addr        = newest_slot;
                        tcnt_wdata       = newest_tcnt_reg + 1'b1;
                        newest_tcnt_next = newest_tcnt_reg + 1'b1;
                    end
                end
                KIND_POP:
                begin
                    if (is_empty) begin
                        res_now.status = STATUS_EMPTY;
                    end else begin
                        rd_en         = 1'b1;
                        head_ptr_next = head_inc;
                        count_next    = count_reg - 1'b1;
                        state_next    = ST_POP_LOAD;
                    end
                end
                KIND_LOOKUP:
                begin
                    if (!held_valid_reg) begin
                        res_now.status = STATUS_NO_HELD;
                    end else begin
                        res_now.popped_time = held_time_reg;
                        res_now.tag_found   = held_match.found;
                        res_now.found_data  = held_match.data;
                    end
                end
                KIND_CLEAR:
                begin
                    head_ptr_next = '0;
                    tail_ptr_next = '0;
                    count_next    = '0;
                end
                default:
                begin
                end
            endcase
        end

        res_now.head_time    = (count_next != '0) ? head_time_next : '0;
        res_now.queued_count = count_next;
    end

    // Result of a pop, built from the registered head slot.
    always_comb
    begin
        res_pop              = '0;
        res_pop.status       = STATUS_OK;
        res_pop.popped_time  = rd_time_reg;
        res_pop.tag_found    = pop_match.found;
        res_pop.found_data   = pop_match.data;
        res_pop.head_time    = (count_reg != '0) ? rd_next_time_reg : '0;
        res_pop.queued_count = count_reg;
    end

    // Output queue bookkeeping.
    assign wr_en     = (acc && !rd_en) || (state_reg == ST_POP_LOAD);
    assign wr_data   = (state_reg == ST_POP_LOAD) ? res_pop : res_now;
    assign res_valid = (fill_reg != '0);
    assign res       = out_q_reg[rd_sel_reg];
    assign rd_take   = res_valid && !res_stall;

    always_comb
    begin
        case ({wr_en, rd_take})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            head_ptr_reg    <= '0;
            tail_ptr_reg    <= '0;
            count_reg       <= '0;
            newest_time_reg <= '0;
            newest_tcnt_reg <= '0;
            head_time_reg   <= '0;
            held_valid_reg  <= 1'b0;
            fill_reg        <= '0;
            wr_sel_reg      <= 1'b0;
            rd_sel_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            head_ptr_reg    <= head_ptr_next;
            tail_ptr_reg    <= tail_ptr_next;
            count_reg       <= count_next;
            newest_time_reg <= newest_time_next;
            newest_tcnt_reg <= newest_tcnt_next;
            head_time_reg   <= head_time_next;
            held_valid_reg  <= held_valid_next;
            fill_reg        <= fill_next;
            if (wr_en) begin
                wr_sel_reg <= !wr_sel_reg;
            end
            if (rd_take) begin
                rd_sel_reg <= !rd_sel_reg;
            end
        end
    end

    // Event memories: tail and newest-slot writes, head-slot reads.
    always_ff @(posedge clk)
    begin
        if (time_we) begin
            time_mem[tail_ptr_reg] <= push_time;
        end
        if (tcnt_we) begin
            tcnt_mem[tcnt_addr] <= tcnt_wdata;
        end
        if (tag_we) begin
            key_mem[newest_slot][lane]  <= cmd.tag_value;
            word_mem[newest_slot][lane] <= cmd.tag_data;
        end
        if (rd_en) begin
            rd_time_reg      <= time_mem[head_ptr_reg];
            rd_next_time_reg <= time_mem[head_inc];
            rd_tcnt_reg      <= tcnt_mem[head_ptr_reg];
            rd_keys_reg      <= key_mem[head_ptr_reg];
            rd_words_reg     <= word_mem[head_ptr_reg];
            query_reg        <= cmd.tag_value;
        end
    end

    // Held event, loaded from the popped slot.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_POP_LOAD) begin
            held_time_reg  <= rd_time_reg;
            held_tcnt_reg  <= rd_tcnt_reg;
            held_keys_reg  <= rd_keys_reg;
            held_words_reg <= rd_words_reg;
        end
    end

    // Output queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            out_q_reg[wr_sel_reg] <= wr_data;
        end
    end

`ifndef SYNTH
    // The output queue never holds more than two results.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("output queue fill out of range");

    // The event count never passes the ring depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("event count exceeds ring depth");

    // A pop on a non-empty queue goes to the load cycle and removes one event.
    a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (kind == KIND_POP) && (count_reg != '0))
        |=> ((state_reg == ST_POP_LOAD) && (count_reg == $past(count_reg) - 1'b1)))
        else $error("pop did not start the load cycle");

    // The load state is followed by idle and leaves a held event.
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_LOAD) |=> ((state_reg == ST_IDLE) && held_valid_reg))
        else $error("pop load did not finish");
`endif

endmodule
